// ===== rtl/ctks_pkg.sv =====
// ----------------------------------------------------------------------------
// ctks_pkg
// Shared types, codes and character classes of the C token scanner.
// ----------------------------------------------------------------------------
package ctks_pkg;

  localparam int unsigned LEN_W     = 7;
  localparam int unsigned OQ_DEPTH  = 4;
  localparam int unsigned OQ_AW     = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  typedef logic [4:0] dfa_state_t;

  // DFA states
  localparam dfa_state_t S_NONE      = 5'd0;
  localparam dfa_state_t S_START     = 5'd1;
  localparam dfa_state_t S_IDENT     = 5'd2;
  localparam dfa_state_t S_NUMBER    = 5'd3;
  localparam dfa_state_t S_OP_EQ1    = 5'd4;
  localparam dfa_state_t S_OP_EQ2    = 5'd5;
  localparam dfa_state_t S_LT        = 5'd6;
  localparam dfa_state_t S_SHL       = 5'd7;
  localparam dfa_state_t S_LE        = 5'd8;
  localparam dfa_state_t S_GT        = 5'd9;
  localparam dfa_state_t S_SHR       = 5'd10;
  localparam dfa_state_t S_GE        = 5'd11;
  localparam dfa_state_t S_MINUS     = 5'd12;
  localparam dfa_state_t S_ARROW     = 5'd13;
  localparam dfa_state_t S_MINUS_EQ  = 5'd14;
  localparam dfa_state_t S_SEP       = 5'd15;
  localparam dfa_state_t S_STAR      = 5'd16;
  localparam dfa_state_t S_STAR_EQ   = 5'd17;
  localparam dfa_state_t S_SLASH     = 5'd18;
  localparam dfa_state_t S_SLASH_EQ  = 5'd19;
  localparam dfa_state_t S_BLK_OPEN  = 5'd20;
  localparam dfa_state_t S_LINE_OPEN = 5'd21;
  localparam dfa_state_t S_AMP       = 5'd22;
  localparam dfa_state_t S_AND_AND   = 5'd23;
  localparam dfa_state_t S_BAR       = 5'd24;
  localparam dfa_state_t S_OR_OR     = 5'd25;
  localparam dfa_state_t S_BLANK     = 5'd26;
  localparam dfa_state_t S_STRING    = 5'd27;

  typedef enum logic [2:0] {
    SM_NORMAL   = 3'd0,
    SM_BLK      = 3'd1,
    SM_BLK_STAR = 3'd2,
    SM_LINE     = 3'd3,
    SM_STR      = 3'd4,
    SM_STR_ESC  = 3'd5
  } scan_mode_t;

  // Event kinds
  localparam logic [1:0] EV_TOKEN = 2'd0;
  localparam logic [1:0] EV_ERROR = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Token classes
  localparam logic [1:0] TC_IDENT = 2'd0;
  localparam logic [1:0] TC_CONST = 2'd1;
  localparam logic [1:0] TC_OPER  = 2'd2;
  localparam logic [1:0] TC_SEP   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_UNKNOWN  = 2'd0;
  localparam logic [1:0] ERR_OPEN_CMT = 2'd1;
  localparam logic [1:0] ERR_NO_QUOTE = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    dfa_state_t        dfa_state;
    scan_mode_t        scan_mode;
    logic              quote_dbl;
    logic [LEN_W-1:0]  lex_cnt;
    logic              cnt_ovf;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [1:0]        token_class;
    dfa_state_t        accept_state;
    logic [1:0]        error_code;
    logic [LEN_W-1:0]  token_length;
    logic              too_long;
    logic              last;
  } result_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) ||
           (b == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_LF) || (b == CH_TAB) || (b == CH_CR) || (b == CH_SPACE);
  endfunction

  // Successor of a non-start state; S_NONE finishes the token.
  function automatic dfa_state_t next_of(input dfa_state_t s, input logic [7:0] b);
    dfa_state_t nx;
    nx = S_NONE;
    unique case (s)
      S_IDENT:  if (is_letter(b) || is_digit(b)) nx = S_IDENT;
      S_NUMBER: if (is_digit(b)) nx = S_NUMBER;
      S_OP_EQ1: if (b == CH_EQ) nx = S_OP_EQ2;
      S_LT: begin
        if (b == CH_LT) nx = S_SHL;
        else if (b == CH_EQ) nx = S_LE;
      end
      S_GT: begin
        if (b == CH_GT) nx = S_SHR;
        else if (b == CH_EQ) nx = S_GE;
      end
      S_MINUS: begin
        if (b == CH_GT) nx = S_ARROW;
        else if (b == CH_EQ) nx = S_MINUS_EQ;
      end
      S_STAR: begin
        if (b == CH_STAR) nx = S_STAR;
        else if (b == CH_EQ) nx = S_STAR_EQ;
      end
      S_SLASH: begin
        if (b == CH_EQ) nx = S_SLASH_EQ;
        else if (b == CH_STAR) nx = S_BLK_OPEN;
        else if (b == CH_SLASH) nx = S_LINE_OPEN;
      end
      S_AMP:   if (b == CH_AMP) nx = S_AND_AND;
      S_BAR:   if (b == CH_BAR) nx = S_OR_OR;
      S_BLANK: if (is_blank(b)) nx = S_BLANK;
      default: nx = S_NONE;
    endcase
    return nx;
  endfunction

  // State entered from start; S_NONE for an unknown character.
  function automatic dfa_state_t start_of(input logic [7:0] b);
    dfa_state_t s;
    s = S_NONE;
    unique case (b)
      CH_BANG, CH_PLUS, CH_PCT, CH_EQ: s = S_OP_EQ1;
      CH_LT:    s = S_LT;
      CH_GT:    s = S_GT;
      CH_MINUS: s = S_MINUS;
      CH_DOT, CH_COMMA, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAR, CH_RPAR,
      CH_LBRK, CH_RBRK, CH_HASH, CH_COLON: s = S_SEP;
      CH_STAR:  s = S_STAR;
      CH_SLASH: s = S_SLASH;
      CH_AMP:   s = S_AMP;
      CH_BAR:   s = S_BAR;
      default: begin
        if (is_letter(b)) s = S_IDENT;
        else if (is_digit(b)) s = S_NUMBER;
        else if (is_blank(b)) s = S_BLANK;
      end
    endcase
    return s;
  endfunction

  // Class of a finished state; valid low for states that give no token.
  function automatic logic [2:0] class_of(input dfa_state_t s);
    logic [2:0] r;
    if (s == S_IDENT) r = {1'b1, TC_IDENT};
    else if (s == S_NUMBER || s == S_STRING) r = {1'b1, TC_CONST};
    else if (s == S_SEP) r = {1'b1, TC_SEP};
    else if ((s >= S_OP_EQ1 && s <= S_MINUS_EQ) || (s >= S_STAR && s <= S_SLASH_EQ) ||
             (s >= S_AMP && s <= S_OR_OR)) r = {1'b1, TC_OPER};
    else r = 3'b000;
    return r;
  endfunction

endpackage

// ===== rtl/ctks_step.sv =====
// ----------------------------------------------------------------------------
// ctks_step
// One scanner step: current state and a byte in, next state and up to two
// results out. Purely combinational.
// ----------------------------------------------------------------------------
module ctks_step #(
  parameter int unsigned MAX_TOKEN_LEN = 127
) (
  input  ctks_pkg::scan_state_t cur,
  input  logic [7:0]            byte_i,
  output ctks_pkg::scan_state_t nxt,
  output logic [1:0]            res_cnt,
  output ctks_pkg::result_t     res0,
  output ctks_pkg::result_t     res1
);
  import ctks_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

  scan_state_t st_nxt;
  logic        st_v;
  result_t     st_res;
  logic        tk_v;
  result_t     tk_res;
  dfa_state_t  st_code;
  dfa_state_t  nx;
  logic [2:0]  cls;
  logic [LEN_W-1:0] bump_cnt;
  logic             bump_ovf;
  scan_state_t idle_st;

  // Saturating lexeme count
  always_comb begin
    if (cur.lex_cnt >= MAX_LEN) begin
      bump_cnt = MAX_LEN;
      bump_ovf = 1'b1;
    end else begin
      bump_cnt = cur.lex_cnt + 1'b1;
      bump_ovf = cur.cnt_ovf;
    end
  end

  always_comb begin
    idle_st           = cur;
    idle_st.dfa_state = S_START;
    idle_st.scan_mode = SM_NORMAL;
    idle_st.lex_cnt   = '0;
    idle_st.cnt_ovf   = 1'b0;
  end

  // Start-state scan of the byte
  always_comb begin
    st_nxt  = idle_st;
    st_v    = 1'b0;
    st_res  = '0;
    st_code = start_of(byte_i);
    if (byte_i == CH_NUL) begin
      st_v = 1'b1;
      st_res.event_kind = EV_END;
    end else if (byte_i == CH_DQUOTE || byte_i == CH_SQUOTE) begin
      st_nxt.scan_mode = SM_STR;
      st_nxt.quote_dbl = (byte_i == CH_DQUOTE);
    end else if (st_code == S_NONE) begin
      st_v = 1'b1;
      st_res.event_kind = EV_ERROR;
      st_res.error_code = ERR_UNKNOWN;
    end else begin
      st_nxt.dfa_state = st_code;
      st_nxt.lex_cnt   = LEN_W'(1);
    end
  end

  always_comb begin
    nxt    = cur;
    tk_v   = 1'b0;
    tk_res = '0;
    res0   = '0;
    res1   = '0;
    res_cnt = 2'd0;
    nx  = next_of(cur.dfa_state, byte_i);
    cls = class_of(cur.dfa_state);
    unique case (cur.scan_mode)
      SM_BLK, SM_BLK_STAR: begin
        if (byte_i == CH_NUL) begin
          tk_v = 1'b1;
          tk_res.event_kind = EV_ERROR;
          tk_res.error_code = ERR_OPEN_CMT;
          nxt = idle_st;
        end else if (cur.scan_mode == SM_BLK_STAR && byte_i == CH_SLASH) begin
          nxt = idle_st;
        end else begin
          nxt.scan_mode = (byte_i == CH_STAR) ? SM_BLK_STAR : SM_BLK;
        end
      end
      SM_LINE: begin
        if (byte_i == CH_LF || byte_i == CH_NUL) begin
          nxt  = st_nxt;
          tk_v = st_v;
          tk_res = st_res;
        end
      end
      SM_STR, SM_STR_ESC: begin
        if (byte_i == CH_NUL) begin
          tk_v = 1'b1;
          tk_res.event_kind = EV_ERROR;
          tk_res.error_code = ERR_NO_QUOTE;
          nxt = idle_st;
        end else if (cur.scan_mode == SM_STR &&
                     byte_i == (cur.quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
          tk_v = 1'b1;
          tk_res.event_kind   = EV_TOKEN;
          tk_res.token_class  = TC_CONST;
          tk_res.accept_state = S_STRING;
          tk_res.token_length = cur.lex_cnt;
          tk_res.too_long     = cur.cnt_ovf;
          nxt = idle_st;
        end else begin
          nxt.lex_cnt = bump_cnt;
          nxt.cnt_ovf = bump_ovf;
          if (cur.scan_mode == SM_STR_ESC) nxt.scan_mode = SM_STR;
          else if (byte_i == CH_BSLASH) nxt.scan_mode = SM_STR_ESC;
        end
      end
      default: begin
        nxt.scan_mode = SM_NORMAL;
        if (cur.dfa_state == S_START) begin
          nxt    = st_nxt;
          tk_v   = st_v;
          tk_res = st_res;
        end else if (nx != S_NONE) begin
          if (nx == S_BLK_OPEN) begin
            nxt = idle_st;
            nxt.scan_mode = SM_BLK;
          end else if (nx == S_LINE_OPEN) begin
            nxt = idle_st;
            nxt.scan_mode = SM_LINE;
          end else begin
            nxt.dfa_state = nx;
            nxt.lex_cnt   = bump_cnt;
            nxt.cnt_ovf   = bump_ovf;
          end
        end else begin
          // finish the token, then rescan the byte from start
          tk_v = cls[2];
          tk_res.event_kind   = EV_TOKEN;
          tk_res.token_class  = cls[1:0];
          tk_res.accept_state = cur.dfa_state;
          tk_res.token_length = cur.lex_cnt;
          tk_res.too_long     = cur.cnt_ovf;
          nxt = st_nxt;
          if (st_v) begin
            if (tk_v) begin
              res1 = st_res;
              res1.last = 1'b1;
            end else begin
              tk_v   = 1'b1;
              tk_res = st_res;
            end
            res_cnt = tk_v && cls[2] ? 2'd2 : 2'd1;
          end
        end
      end
    endcase
    res0 = tk_res;
    if (res_cnt == 2'd0) res_cnt = {1'b0, tk_v};
    res0.last = (res_cnt == 2'd1);
  end

endmodule

// ===== rtl/ctks_outq.sv =====
// ----------------------------------------------------------------------------
// ctks_outq
// Small result queue: takes up to two results a cycle, hands out one beat.
// ----------------------------------------------------------------------------
module ctks_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_n,
  input  ctks_pkg::result_t            push_d0,
  input  ctks_pkg::result_t            push_d1,
  input  logic                         pop,
  output logic [ctks_pkg::OQ_CNT_W-1:0] count,
  output ctks_pkg::result_t            head
);
  import ctks_pkg::*;

  result_t               mem [OQ_DEPTH];
  logic [OQ_AW-1:0]      wr_ptr_r;
  logic [OQ_AW-1:0]      rd_ptr_r;
  logic [OQ_CNT_W-1:0]   cnt_r;
  logic [OQ_CNT_W-1:0]   cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_AW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr_r] <= push_d0;
    if (push_n == 2'd2) mem[wr_ptr_r + 1'b1] <= push_d1;
  end

  assign count = cnt_r;
  assign head  = mem[rd_ptr_r];

endmodule

// ===== rtl/c_token_scanner.sv =====
// ----------------------------------------------------------------------------
// c_token_scanner
// Byte-serial C lexical scanner with a streamed result channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one source byte per beat in in_tdata; byte 0 marks end of input.
//   out_* : one result per beat; out_tuser carries the event kind (token,
//           lexical error, end of input), out_tdata the token details, and
//           out_tlast marks the final result caused by an input byte.
//   A byte is registered on acceptance in the input stage, stepped through
//   the DFA from that register and its results written into a four-entry
//   queue; the first result shows on out_tvalid once the queue's registered
//   count is nonzero. Throughput is one byte per cycle while the queue has
//   room. The step advances only while the queue holds room for two results,
//   so a byte that yields both a token and an end or error result costs one
//   extra queue slot. When the receiver stalls, the queue fills and
//   in_tready drops; no result is lost or reordered.
//   Reset puts the DFA in its start state with normal scanning, and empties
//   the input stage and the queue.
// ----------------------------------------------------------------------------
module c_token_scanner #(
  parameter int unsigned MAX_TOKEN_LEN = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] source_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [1:0] token_class, [6:2] accept_state,
                                   // [8:7] error_code, [15:9] token_length,
                                   // [16] too_long, [23:17] zero
  output logic [1:0]  out_tuser,   // [1:0] event_kind
  output logic        out_tlast
);
  import ctks_pkg::*;

  logic                stg_v_r;
  logic [7:0]          stg_byte_r;
  scan_state_t         st_r;
  scan_state_t         st_nxt;
  logic [1:0]          res_cnt;
  result_t             res0;
  result_t             res1;
  logic                adv;
  logic [OQ_CNT_W-1:0] q_cnt;
  result_t             q_head;
  logic                in_acc;
  logic                pop;

  assign adv       = stg_v_r && (q_cnt <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign in_tready = !stg_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_acc) begin
      stg_v_r <= 1'b1;
    end else if (adv) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) stg_byte_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.dfa_state <= S_START;
      st_r.scan_mode <= SM_NORMAL;
      st_r.quote_dbl <= 1'b0;
      st_r.lex_cnt   <= '0;
      st_r.cnt_ovf   <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  ctks_step #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_step (
    .cur     (st_r),
    .byte_i  (stg_byte_r),
    .nxt     (st_nxt),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  assign pop = out_tvalid && out_tready;

  ctks_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (adv ? res_cnt : 2'd0),
    .push_d0 (res0),
    .push_d1 (res1),
    .pop     (pop),
    .count   (q_cnt),
    .head    (q_head)
  );

  assign out_tvalid = (q_cnt != '0);
  assign out_tuser  = q_head.event_kind;
  assign out_tlast  = q_head.last;
  assign out_tdata  = {7'd0, q_head.too_long, q_head.token_length, q_head.error_code,
                       q_head.accept_state, q_head.token_class};

endmodule

// ===== tb/sv/c_token_scanner_test.sv =====
// ----------------------------------------------------------------------------
// c_token_scanner_test
// Self-checking bench for the byte-serial C token scanner. A short directed
// table covers end of input, unknown bytes, the unterminated string and
// comment errors and a star run. Random source text follows: identifiers,
// numbers, operators, strings, comments and noise, some of them over-long.
// Each beat is checked against a behavioral scanner kept in the bench, or
// against a table row's typed results, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module c_token_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctks_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int MAX_LEN      = 127;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 16;

  localparam string WORD_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string SEP_CHARS = ".,;{}()[]#:";
  localparam string OPS[26] = '{"!", "!=", "+", "+=", "%", "%=", "=", "==",
                                "<", "<<", "<=", ">", ">>", ">=", "-", "->",
                                "-=", "*", "***", "**=", "/", "/=", "&", "&&",
                                "|", "||"};

  typedef struct {
    logic [7:0] ch;
    int         n_typed;   // -1: take the scanner model's results
    result_t    r0;
    result_t    r1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] source_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [1:0] token_class, [6:2] accept_state,
                            // [8:7] error_code, [15:9] token_length,
                            // [16] too_long, [23:17] zero
  logic [1:0]  out_tuser;   // [1:0] event_kind
  logic        out_tlast;

  // scanner model state
  dfa_state_t  lx_state;
  scan_mode_t  lx_mode;
  logic        lx_dquote;
  logic [6:0]  lx_len;
  logic        lx_ovf;
  result_t     step_res[2];
  int          step_n;

  result_t     expected_results[$];
  stim_row_t   dir_rows[$];
  logic [7:0]  src_q[$];
  int          n_fail = 0;

  // sideband of the beat on in_tdata
  int          cur_typed = -1;
  result_t     cur_r0;
  result_t     cur_r1;

  int          burst_left = 0;
  int          tx_mode = 1;
  int          tx_count = 0;
  int          rx_hold = 0;
  int          rx_mode = 0;
  int          rx_cycle = 0;

  c_token_scanner #(
    .MAX_TOKEN_LEN(MAX_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic result_t mk_res(input logic [1:0] kind, input logic [1:0] cls,
                                     input dfa_state_t acc, input logic [1:0] code,
                                     input logic [6:0] len, input logic tl,
                                     input logic lst);
    result_t r;
    r.event_kind   = kind;
    r.token_class  = cls;
    r.accept_state = acc;
    r.error_code   = code;
    r.token_length = len;
    r.too_long     = tl;
    r.last         = lst;
    return r;
  endfunction

  function automatic void lex_emit(input logic [1:0] kind, input logic [1:0] cls,
                                   input dfa_state_t acc, input logic [1:0] code,
                                   input logic [6:0] len, input logic tl);
    step_res[step_n] = mk_res(kind, cls, acc, code, len, tl, 1'b0);
    step_n++;
  endfunction

  function automatic bit is_word_head(input logic [7:0] b);
    return b inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], CH_UNDER};
  endfunction

  function automatic bit is_dec(input logic [7:0] b);
    return b inside {[CH_0:CH_9]};
  endfunction

  function automatic bit is_space(input logic [7:0] b);
    return b inside {CH_LF, CH_TAB, CH_CR, CH_SPACE};
  endfunction

  // Successor inside a token; S_NONE ends it.
  function automatic dfa_state_t lex_next(input dfa_state_t s, input logic [7:0] b);
    case (s)
      S_IDENT:  if (is_word_head(b) || is_dec(b)) return S_IDENT;
      S_NUMBER: if (is_dec(b)) return S_NUMBER;
      S_OP_EQ1: if (b == CH_EQ) return S_OP_EQ2;
      S_LT: begin
        if (b == CH_LT) return S_SHL;
        if (b == CH_EQ) return S_LE;
      end
      S_GT: begin
        if (b == CH_GT) return S_SHR;
        if (b == CH_EQ) return S_GE;
      end
      S_MINUS: begin
        if (b == CH_GT) return S_ARROW;
        if (b == CH_EQ) return S_MINUS_EQ;
      end
      S_STAR: begin
        if (b == CH_STAR) return S_STAR;
        if (b == CH_EQ) return S_STAR_EQ;
      end
      S_SLASH: begin
        if (b == CH_EQ) return S_SLASH_EQ;
        if (b == CH_STAR) return S_BLK_OPEN;
        if (b == CH_SLASH) return S_LINE_OPEN;
      end
      S_AMP:   if (b == CH_AMP) return S_AND_AND;
      S_BAR:   if (b == CH_BAR) return S_OR_OR;
      S_BLANK: if (is_space(b)) return S_BLANK;
      default: return S_NONE;
    endcase
    return S_NONE;
  endfunction

  function automatic dfa_state_t lex_entry(input logic [7:0] b);
    if (b inside {CH_BANG, CH_PLUS, CH_PCT, CH_EQ}) return S_OP_EQ1;
    if (b == CH_LT) return S_LT;
    if (b == CH_GT) return S_GT;
    if (b == CH_MINUS) return S_MINUS;
    if (b inside {CH_DOT, CH_COMMA, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAR, CH_RPAR,
                  CH_LBRK, CH_RBRK, CH_HASH, CH_COLON}) return S_SEP;
    if (b == CH_STAR) return S_STAR;
    if (b == CH_SLASH) return S_SLASH;
    if (b == CH_AMP) return S_AMP;
    if (b == CH_BAR) return S_BAR;
    if (is_word_head(b)) return S_IDENT;
    if (is_dec(b)) return S_NUMBER;
    if (is_space(b)) return S_BLANK;
    return S_NONE;
  endfunction

  // Token class of a finished state, -1 when the state yields no token.
  function automatic int lex_class(input dfa_state_t s);
    case (s)
      S_IDENT: return int'(TC_IDENT);
      S_NUMBER, S_STRING: return int'(TC_CONST);
      S_SEP: return int'(TC_SEP);
      S_OP_EQ1, S_OP_EQ2, S_LT, S_SHL, S_LE, S_GT, S_SHR, S_GE, S_MINUS, S_ARROW,
      S_MINUS_EQ, S_STAR, S_STAR_EQ, S_SLASH, S_SLASH_EQ, S_AMP, S_AND_AND, S_BAR,
      S_OR_OR: return int'(TC_OPER);
      default: return -1;
    endcase
  endfunction

  function automatic void lex_to_start();
    lx_state = S_START;
    lx_mode  = SM_NORMAL;
    lx_len   = '0;
    lx_ovf   = 1'b0;
  endfunction

  function automatic void lex_bump();
    if (lx_len >= MAX_LEN) begin
      lx_len = 7'(MAX_LEN);
      lx_ovf = 1'b1;
    end else begin
      lx_len++;
    end
  endfunction

  function automatic void lex_begin(input logic [7:0] b);
    dfa_state_t s;
    lex_to_start();
    if (b == CH_NUL) begin
      lex_emit(EV_END, '0, S_NONE, '0, '0, 1'b0);
      return;
    end
    if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      lx_mode   = SM_STR;
      lx_dquote = (b == CH_DQUOTE);
      return;
    end
    s = lex_entry(b);
    if (s == S_NONE) begin
      lex_emit(EV_ERROR, '0, S_NONE, ERR_UNKNOWN, '0, 1'b0);
      return;
    end
    lx_state = s;
    lx_len   = 7'd1;
  endfunction

  function automatic void lex_scan(input logic [7:0] b);
    dfa_state_t nx;
    int cls;
    if (lx_state == S_START) begin
      lex_begin(b);
      return;
    end
    nx = lex_next(lx_state, b);
    if (nx != S_NONE) begin
      lex_bump();
      if (nx == S_BLK_OPEN) begin
        lex_to_start();
        lx_mode = SM_BLK;
      end else if (nx == S_LINE_OPEN) begin
        lex_to_start();
        lx_mode = SM_LINE;
      end else begin
        lx_state = nx;
      end
      return;
    end
    // token ends here; the byte is scanned again from start
    cls = lex_class(lx_state);
    if (cls >= 0) lex_emit(EV_TOKEN, cls[1:0], lx_state, '0, lx_len, lx_ovf);
    lex_begin(b);
  endfunction

  function automatic void lex_step(input logic [7:0] b);
    step_n = 0;
    case (lx_mode)
      SM_BLK, SM_BLK_STAR: begin
        if (b == CH_NUL) begin
          lex_emit(EV_ERROR, '0, S_NONE, ERR_OPEN_CMT, '0, 1'b0);
          lex_to_start();
        end else if (lx_mode == SM_BLK_STAR && b == CH_SLASH) begin
          lex_to_start();
        end else begin
          lx_mode = (b == CH_STAR) ? SM_BLK_STAR : SM_BLK;
        end
      end
      SM_LINE: if (b == CH_LF || b == CH_NUL) lex_begin(b);
      SM_STR: begin
        if (b == CH_NUL) begin
          lex_emit(EV_ERROR, '0, S_NONE, ERR_NO_QUOTE, '0, 1'b0);
          lex_to_start();
        end else if (b == (lx_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
          lex_emit(EV_TOKEN, TC_CONST, S_STRING, '0, lx_len, lx_ovf);
          lex_to_start();
        end else begin
          lex_bump();
          if (b == CH_BSLASH) lx_mode = SM_STR_ESC;
        end
      end
      SM_STR_ESC: begin
        if (b == CH_NUL) begin
          lex_emit(EV_ERROR, '0, S_NONE, ERR_NO_QUOTE, '0, 1'b0);
          lex_to_start();
        end else begin
          lex_bump();
          lx_mode = SM_STR;
        end
      end
      default: begin
        lx_mode = SM_NORMAL;
        lex_scan(b);
      end
    endcase
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic void cmp_field(input string name, input int e, input int a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      n_fail++;
    end
  endfunction

  function automatic void check_result(input result_t e, input result_t a);
    cmp_field("event_kind", e.event_kind, a.event_kind);
    cmp_field("token_class", e.token_class, a.token_class);
    cmp_field("accept_state", e.accept_state, a.accept_state);
    cmp_field("error_code", e.error_code, a.error_code);
    cmp_field("token_length", e.token_length, a.token_length);
    cmp_field("too_long", e.too_long, a.too_long);
    cmp_field("last", e.last, a.last);
  endfunction

  function automatic void add_row(input logic [7:0] ch, input int n_typed,
                                  input result_t r0, input result_t r1);
    stim_row_t row;
    row.ch      = ch;
    row.n_typed = n_typed;
    row.r0      = r0;
    row.r1      = r1;
    dir_rows.push_back(row);
  endfunction

  // Check beats leaving the block, then predict for the beat taken in.
  always @(posedge clk) begin
    result_t act;
    int k;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        act = mk_res(out_tuser, out_tdata[1:0], out_tdata[6:2], out_tdata[8:7],
                     out_tdata[15:9], out_tdata[16], out_tlast);
        if (expected_results.size() == 0) begin
          $error("result beat with none expected: event_kind %0d", out_tuser);
          n_fail++;
        end else begin
          check_result(expected_results.pop_front(), act);
        end
      end
      if (in_tvalid && in_tready) begin
        lex_step(in_tdata);
        if (cur_typed < 0) begin
          for (k = 0; k < step_n; k++) expected_results.push_back(step_res[k]);
        end else begin
          if (cur_typed > 0) expected_results.push_back(cur_r0);
          if (cur_typed > 1) expected_results.push_back(cur_r1);
        end
      end
    end
  end

  // Receiver: always ready, random stalls, or occasional long holds.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(4, 24);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
    rx_cycle++;
    if (rx_cycle % 250 == 0) rx_mode = $urandom_range(0, 2);
  end

  task automatic send_item(input logic [7:0] b, input int n_typed,
                           input result_t r0, input result_t r1);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (tx_mode == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    cur_typed <= n_typed;
    cur_r0    <= r0;
    cur_r1    <= r1;
    do @(posedge clk); while (!in_tready);
    tx_count++;
    if (tx_count % 300 == 0) tx_mode = $urandom_range(0, 2);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Append one piece of source text; counted is the number of bytes added.
  task automatic gen_fragment(output int counted);
    int r;
    int len;
    int k;
    int n0;
    logic [7:0] c;
    logic [7:0] quote;
    string op;
    n0 = src_q.size();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(118, 135) : $urandom_range(1, 10);
      src_q.push_back(WORD_CHARS[$urandom_range(0, 52)]);
      for (k = 1; k < len; k++) src_q.push_back(WORD_CHARS[$urandom_range(0, 62)]);
    end else if (r < 35) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(124, 132) : $urandom_range(1, 8);
      for (k = 0; k < len; k++) src_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end else if (r < 55) begin
      op = OPS[$urandom_range(0, 25)];
      for (k = 0; k < op.len(); k++) src_q.push_back(op[k]);
    end else if (r < 63) begin
      src_q.push_back(SEP_CHARS[$urandom_range(0, 10)]);
    end else if (r < 73) begin
      len = $urandom_range(1, 4);
      for (k = 0; k < len; k++) src_q.push_back(blank_char());
    end else if (r < 81) begin
      quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 135) : $urandom_range(0, 12);
      src_q.push_back(quote);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          src_q.push_back(CH_BSLASH);
          src_q.push_back(8'($urandom_range(1, 255)));
        end else begin
          c = 8'($urandom_range(1, 255));
          if (c == quote) c = CH_LC_A;
          src_q.push_back(c);
        end
      end
      // leave some strings open, a few of them right after a backslash
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 1) src_q.push_back(CH_BSLASH);
        src_q.push_back(CH_NUL);
      end else begin
        src_q.push_back(quote);
      end
    end else if (r < 87) begin
      src_q.push_back(CH_SLASH);
      src_q.push_back(CH_STAR);
      len = $urandom_range(0, 10);
      for (k = 0; k < len; k++)
        src_q.push_back(($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(1, 255)));
      if ($urandom_range(0, 5) == 0) begin
        src_q.push_back(CH_NUL);
      end else begin
        src_q.push_back(CH_STAR);
        src_q.push_back(CH_SLASH);
      end
    end else if (r < 91) begin
      src_q.push_back(CH_SLASH);
      src_q.push_back(CH_SLASH);
      len = $urandom_range(0, 10);
      for (k = 0; k < len; k++) begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_LF) c = CH_SPACE;
        src_q.push_back(c);
      end
      src_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_LF);
    end else if (r < 96) begin
      src_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      src_q.push_back(CH_NUL);
    end
    counted = src_q.size() - n0;
  endtask

  initial begin
    result_t r_end;
    result_t r_none;
    int counted;
    int total;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cur_r0     = '0;
    cur_r1     = '0;
    lex_to_start();
    lx_dquote  = 1'b0;

    r_end  = mk_res(EV_END, '0, S_NONE, '0, '0, 1'b0, 1'b1);
    r_none = '0;
    add_row(CH_NUL, 1, r_end, r_none);
    add_row(8'hFF, 1, mk_res(EV_ERROR, '0, S_NONE, ERR_UNKNOWN, '0, 1'b0, 1'b1), r_none);
    add_row(CH_LC_A, -1, r_none, r_none);
    add_row(CH_UC_Z, -1, r_none, r_none);
    add_row(CH_UNDER, -1, r_none, r_none);
    add_row(CH_9, -1, r_none, r_none);
    add_row(CH_NUL, 2, mk_res(EV_TOKEN, TC_IDENT, S_IDENT, '0, 7'd4, 1'b0, 1'b0), r_end);
    add_row(CH_DQUOTE, -1, r_none, r_none);
    add_row(CH_BSLASH, -1, r_none, r_none);
    add_row(CH_DQUOTE, -1, r_none, r_none);
    add_row(CH_NUL, 1, mk_res(EV_ERROR, '0, S_NONE, ERR_NO_QUOTE, '0, 1'b0, 1'b1), r_none);
    add_row(CH_SLASH, -1, r_none, r_none);
    add_row(CH_STAR, -1, r_none, r_none);
    add_row(CH_STAR, -1, r_none, r_none);
    add_row(CH_NUL, 1, mk_res(EV_ERROR, '0, S_NONE, ERR_OPEN_CMT, '0, 1'b0, 1'b1), r_none);
    add_row(CH_SQUOTE, -1, r_none, r_none);
    add_row(CH_BSLASH, -1, r_none, r_none);
    add_row(CH_NUL, 1, mk_res(EV_ERROR, '0, S_NONE, ERR_NO_QUOTE, '0, 1'b0, 1'b1), r_none);
    add_row(8'h80, 1, mk_res(EV_ERROR, '0, S_NONE, ERR_UNKNOWN, '0, 1'b0, 1'b1), r_none);
    add_row(CH_STAR, -1, r_none, r_none);
    add_row(CH_STAR, -1, r_none, r_none);
    add_row(CH_EQ, -1, r_none, r_none);
    add_row(CH_0, -1, r_none, r_none);
    add_row(CH_SLASH, -1, r_none, r_none);
    add_row(CH_SLASH, -1, r_none, r_none);
    add_row(8'h80, -1, r_none, r_none);
    add_row(CH_NUL, 1, r_end, r_none);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].ch, dir_rows[i].n_typed, dir_rows[i].r0, dir_rows[i].r1);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      gen_fragment(counted);
      total += counted;
      while (src_q.size() > 0) send_item(src_q.pop_front(), -1, r_none, r_none);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ctks_pkg.sv
rtl/ctks_step.sv
rtl/ctks_outq.sv
rtl/c_token_scanner.sv
tb/sv/c_token_scanner_test.sv
